FILE: rtl/rrbb_pkg.sv
// rrbb_pkg: types, constants and the arctangent table of the rotated-rectangle bounding box
// shared by rrbb_cell, rrbb_extent and rotated_rect_bounding_box_top
// no dependencies
package rrbb_pkg;

  // default parameter values
  localparam int unsigned ANGLE_BITS_DEF    = 16;
  localparam int unsigned TRIG_FRAC_DEF     = 15;

  // field widths
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned BOX_W   = 32;

  // size times scale magnitude
  localparam int unsigned AB_W = SIZE_W + SCALE_W;

  // rotator datapath, turn angle in 32-bit units and Q2.30 vectors with headroom
  localparam int unsigned TURN_W        = 32;
  localparam int unsigned CS_W          = 34;
  localparam int unsigned CORDIC_STEPS  = 28;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-i in 32-bit turn units
  localparam logic [TURN_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  // input transaction
  typedef struct packed {
    logic        [SIZE_W-1:0]  size_x;
    logic        [SIZE_W-1:0]  size_y;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic        [ANGLE_W-1:0] angle;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
  } rrbb_in_t;

  // output transaction
  typedef struct packed {
    logic signed [BOX_W-1:0] min_x;
    logic signed [BOX_W-1:0] min_y;
    logic signed [BOX_W-1:0] max_x;
    logic signed [BOX_W-1:0] max_y;
  } rrbb_out_t;

  // rotator state handed from cell to cell
  typedef struct packed {
    logic signed [CS_W-1:0] x;
    logic signed [CS_W-1:0] y;
    logic signed [CS_W-1:0] z;
  } rrbb_cs_t;

  // geometry carried alongside the rotator
  typedef struct packed {
    logic        [AB_W-1:0]  a;
    logic        [AB_W-1:0]  b;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } rrbb_side_t;

endpackage

FILE: rtl/rrbb_cell.sv
// rrbb_cell: one rotation step of the sine/cosine chain, registered
// depends on rrbb_pkg
module rrbb_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rrbb_pkg::rrbb_cs_t   cs_i,
  input  rrbb_pkg::rrbb_side_t side_i,
  output logic                valid_o,
  output rrbb_pkg::rrbb_cs_t   cs_o,
  output rrbb_pkg::rrbb_side_t side_o
);
  import rrbb_pkg::*;

  localparam logic signed [CS_W-1:0] ATAN = CS_W'(CORDIC_ATAN[STEP]);

  logic signed [CS_W-1:0] x_in, y_in, z_in, dx, dy;
  rrbb_cs_t               cs_d;
  rrbb_cs_t               cs_q;
  rrbb_side_t             side_q;
  logic                   valid_q;

  // micro-rotation towards zero residual angle
  always_comb begin
    x_in = cs_i.x;
    y_in = cs_i.y;
    z_in = cs_i.z;
    dx   = y_in >>> STEP;
    dy   = x_in >>> STEP;
    if (!z_in[CS_W-1]) begin
      cs_d.x = x_in - dx;
      cs_d.y = y_in + dy;
      cs_d.z = z_in - ATAN;
    end else begin
      cs_d.x = x_in + dx;
      cs_d.y = y_in - dy;
      cs_d.z = z_in + ATAN;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs_q   <= cs_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign cs_o    = cs_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/rrbb_extent.sv
// rrbb_extent: trig rounding, half-extent products, rounding and saturating box edges
// depends on rrbb_pkg
module rrbb_extent #(
  parameter int unsigned TRIG_FRACTION_BITS = rrbb_pkg::TRIG_FRAC_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rrbb_pkg::rrbb_cs_t   cs_i,
  input  rrbb_pkg::rrbb_side_t side_i,
  output logic                 valid_o,
  output rrbb_pkg::rrbb_out_t  res_o
);
  import rrbb_pkg::*;

  localparam int unsigned TFB  = TRIG_FRACTION_BITS;
  localparam int unsigned SH_T = 30 - TFB;
  localparam int unsigned R_W  = CS_W + 1 - SH_T;
  localparam int unsigned P_W  = AB_W + TFB;
  localparam int unsigned E_W  = P_W + 1;
  localparam int unsigned SH_E = 9 + TFB;
  localparam int unsigned HX_W = E_W + 1 - SH_E;
  localparam int unsigned S_W  = HX_W + 2;

  localparam logic [CS_W:0]  HALF_T = (CS_W+1)'(1) << (SH_T - 1);
  localparam logic [R_W-1:0] LIM    = R_W'((64'd1 << TFB) - 64'd1);
  localparam logic [E_W:0]   HALF_E = (E_W+1)'(1) << (SH_E - 1);

  // round a Q2.30 value to TFB fraction bits, clamp, keep the magnitude
  function automatic logic [TFB-1:0] trig_mag(input logic signed [CS_W-1:0] v);
    logic [CS_W:0]  s;
    logic [R_W-1:0] r;
    logic [R_W-1:0] m;
    s = {v[CS_W-1], v} + HALF_T;
    r = s[CS_W:SH_T];
    m = r[R_W-1] ? (~r + R_W'(1)) : r;
    if (m > LIM) begin
      m = LIM;
    end
    return m[TFB-1:0];
  endfunction

  // clamp a signed sum into the 32-bit box range
  function automatic logic [BOX_W-1:0] sat_box(input logic [S_W-1:0] s);
    logic over;
    over = (s[S_W-1:BOX_W-1] != '0) && (s[S_W-1:BOX_W-1] != '1);
    if (!over) begin
      return s[BOX_W-1:0];
    end else if (s[S_W-1]) begin
      return {1'b1, {(BOX_W-1){1'b0}}};
    end else begin
      return {1'b0, {(BOX_W-1){1'b1}}};
    end
  endfunction

  // stage 1: cosine and sine magnitudes
  logic                    v1_q;
  logic [TFB-1:0]          ac_q, as_q;
  rrbb_side_t              sd1_q;
  // stage 2: the four products
  logic                    v2_q;
  logic [P_W-1:0]          p_ac_q, p_bs_q, p_as_q, p_bc_q;
  logic signed [POS_W-1:0] px2_q, py2_q;
  // stage 3: unrounded half-extents
  logic                    v3_q;
  logic [E_W-1:0]          ex_q, ey_q;
  logic signed [POS_W-1:0] px3_q, py3_q;
  // stage 4: half-extents in Q.8
  logic                    v4_q;
  logic [HX_W-1:0]         hx_q, hy_q;
  logic signed [POS_W-1:0] px4_q, py4_q;

  logic [E_W:0]            ex_r, ey_r;
  logic [S_W-1:0]          px_s, py_s, hx_s, hy_s;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign ex_r = {1'b0, ex_q} + HALF_E;
  assign ey_r = {1'b0, ey_q} + HALF_E;

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q   <= trig_mag(cs_i.x);
      as_q   <= trig_mag(cs_i.y);
      sd1_q  <= side_i;

      p_ac_q <= P_W'(sd1_q.a) * P_W'(ac_q);
      p_bs_q <= P_W'(sd1_q.b) * P_W'(as_q);
      p_as_q <= P_W'(sd1_q.a) * P_W'(as_q);
      p_bc_q <= P_W'(sd1_q.b) * P_W'(ac_q);
      px2_q  <= sd1_q.pos_x;
      py2_q  <= sd1_q.pos_y;

      ex_q   <= {1'b0, p_ac_q} + {1'b0, p_bs_q};
      ey_q   <= {1'b0, p_as_q} + {1'b0, p_bc_q};
      px3_q  <= px2_q;
      py3_q  <= py2_q;

      hx_q   <= ex_r[E_W:SH_E];
      hy_q   <= ey_r[E_W:SH_E];
      px4_q  <= px3_q;
      py4_q  <= py3_q;
    end
  end

  // box edges: centre minus and plus half-extent, saturated
  assign px_s = {{(S_W-POS_W){px4_q[POS_W-1]}}, px4_q};
  assign py_s = {{(S_W-POS_W){py4_q[POS_W-1]}}, py4_q};
  assign hx_s = {2'b00, hx_q};
  assign hy_s = {2'b00, hy_q};

  assign res_o.min_x = sat_box(px_s - hx_s);
  assign res_o.min_y = sat_box(py_s - hy_s);
  assign res_o.max_x = sat_box(px_s + hx_s);
  assign res_o.max_y = sat_box(py_s + hy_s);
  assign valid_o     = v4_q;

endmodule

FILE: rtl/rotated_rect_bounding_box_top.sv
// Axis-aligned bounding box of a scaled and rotated sprite rectangle. One transaction is
// taken every clock cycle while in_ready_o is high; a result is offered on the output once
// its input has passed 34 registers (one entry stage, a chain of 28 rotation cells
// producing sine and cosine, four extent stages and the output register). The chain stalls
// as a whole only when both the output register and its skid register are full, so
// in_ready_o is a registered signal. No state is kept between transactions and nothing
// needs clearing after reset.
// depends on rrbb_pkg, rrbb_cell, rrbb_extent
module rotated_rect_bounding_box_top #(
  parameter int unsigned ANGLE_BITS         = rrbb_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TRIG_FRACTION_BITS = rrbb_pkg::TRIG_FRAC_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rrbb_pkg::rrbb_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rrbb_pkg::rrbb_out_t out_data_o
);
  import rrbb_pkg::*;

  localparam logic [TURN_W-1:0] AMASK   = TURN_W'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic [TURN_W-1:0] QUARTER = TURN_W'(64'h4000_0000);

  logic                 en;
  logic                 valid_w [CORDIC_STEPS+1];
  rrbb_cs_t             cs_w    [CORDIC_STEPS+1];
  rrbb_side_t           side_w  [CORDIC_STEPS+1];

  logic [TURN_W-1:0]    turn, turn_off;
  logic                 flip;
  logic [SCALE_W-1:0]   kx_mag, ky_mag;
  rrbb_cs_t             fr_cs_d;
  rrbb_side_t           fr_side_d;
  logic                 fr_valid_q;
  rrbb_cs_t             fr_cs_q;
  rrbb_side_t           fr_side_q;

  logic                 res_valid;
  rrbb_out_t            res;
  logic                 out_valid_q, skid_valid_q;
  rrbb_out_t            out_q, skid_q;
  logic                 take;

  // pipeline moves whenever the skid register is free
  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  // angle to 32-bit turn, left half-plane turned by half a turn (sign irrelevant to |cos|, |sin|)
  always_comb begin
    turn     = (TURN_W'(in_data_i.angle) & AMASK) << (TURN_W - ANGLE_BITS);
    turn_off = turn - QUARTER;
    flip     = !turn_off[TURN_W-1];
    fr_cs_d.x = CORDIC_GAIN;
    fr_cs_d.y = '0;
    fr_cs_d.z = CS_W'(signed'({turn[TURN_W-1] ^ flip, turn[TURN_W-2:0]}));
  end

  // scale magnitudes and size products
  always_comb begin
    kx_mag = in_data_i.scale_x[SCALE_W-1] ? (~in_data_i.scale_x + SCALE_W'(1))
                                           : in_data_i.scale_x;
    ky_mag = in_data_i.scale_y[SCALE_W-1] ? (~in_data_i.scale_y + SCALE_W'(1))
                                           : in_data_i.scale_y;
    fr_side_d.a     = AB_W'(in_data_i.size_x) * AB_W'(kx_mag);
    fr_side_d.b     = AB_W'(in_data_i.size_y) * AB_W'(ky_mag);
    fr_side_d.pos_x = in_data_i.pos_x;
    fr_side_d.pos_y = in_data_i.pos_y;
  end

  // entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else if (en) begin
      fr_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fr_cs_q   <= fr_cs_d;
      fr_side_q <= fr_side_d;
    end
  end

  assign valid_w[0] = fr_valid_q;
  assign cs_w[0]    = fr_cs_q;
  assign side_w[0]  = fr_side_q;

  // chain of rotation cells
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    rrbb_cell #(
      .STEP(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid_w[i]),
      .cs_i   (cs_w[i]),
      .side_i (side_w[i]),
      .valid_o(valid_w[i+1]),
      .cs_o   (cs_w[i+1]),
      .side_o (side_w[i+1])
    );
  end

  // extents and box edges
  rrbb_extent #(
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_extent (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(valid_w[CORDIC_STEPS]),
    .cs_i   (cs_w[CORDIC_STEPS]),
    .side_i (side_w[CORDIC_STEPS]),
    .valid_o(res_valid),
    .res_o  (res)
  );

  // output register with skid register behind it
  assign take = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (en && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (en && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
